// File: hdl/emv_pkg.sv
// Shared types and constants for the triangle mesh edge validator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package emv_pkg;

    // Fixed widths of the channel fields.
    localparam int CoordInW = 16;
    localparam int LimitW   = 8;
    localparam int StatusW  = 3;
    localparam int TriOutW  = 8;
    localparam int EdgeOutW = 9;

    // Defaults for the top-level parameters.
    localparam int DefMaxTriangles = 128;
    localparam int DefCoordWidth   = 16;

    // Each accepted triangle adds this many edges.
    localparam int EdgesPerTri = 3;

    // Slot index of the vertex that completes a triangle.
    localparam logic [1:0] SlotLast = 2'd2;

    typedef enum logic [StatusW-1:0] {
        STAT_STORED   = 3'd0,
        STAT_ACCEPTED = 3'd1,
        STAT_DEGEN    = 3'd2,
        STAT_NO_EDGE  = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PUSH,
        S_EMIT
    } t_state;

    // What every edge cell does in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_PUSH
    } t_cell_op;

endpackage

// File: hdl/emv_in_if.sv
// Input channel of the edge validator: one vertex or clear item per beat.
// Depends on emv_pkg for the field widths.
`timescale 1ns / 1ps

interface emv_in_if;
    import emv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [CoordInW-1:0] vx;
    logic signed [CoordInW-1:0] vy;
    logic signed [CoordInW-1:0] vz;

    modport source (output valid, kind, vx, vy, vz, input ready);
    modport sink   (input valid, kind, vx, vy, vz, output ready);
endinterface

// File: hdl/emv_out_if.sv
// Result channel of the edge validator: one status beat per input item.
// Depends on emv_pkg for the field widths.
`timescale 1ns / 1ps

interface emv_out_if;
    import emv_pkg::*;

    logic                valid;
    logic                ready;
    logic [StatusW-1:0]  status;
    logic [TriOutW-1:0]  triangles_accepted;
    logic [EdgeOutW-1:0] edges_stored;

    modport source (output valid, status, triangles_accepted, edges_stored, input ready);
    modport sink   (input valid, status, triangles_accepted, edges_stored, output ready);
endinterface

// File: hdl/emv_cfg_if.sv
// Configuration write channel of the edge validator (triangle limit).
// Depends on emv_pkg for the register width.
`timescale 1ns / 1ps

interface emv_cfg_if;
    import emv_pkg::*;

    logic              valid;
    logic              ready;
    logic [LimitW-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hdl/emv_edge_cell.sv
// One cell of the edge ring: holds a single stored edge.
// Depends on emv_pkg for the cell operation codes.
`timescale 1ns / 1ps

module emv_edge_cell #(
    parameter int EDGE_WIDTH = 6 * emv_pkg::DefCoordWidth
) (
    input  logic                  i_clk,
    input  emv_pkg::t_cell_op     i_op,
    input  logic                  i_is_last,
    input  logic [EDGE_WIDTH-1:0] i_next,
    input  logic [EDGE_WIDTH-1:0] i_wrap,
    input  logic [EDGE_WIDTH-1:0] i_push,
    output logic [EDGE_WIDTH-1:0] o_edge
);
    import emv_pkg::*;

    logic [EDGE_WIDTH-1:0] r_edge;
    logic [EDGE_WIDTH-1:0] n_edge;

    // The last valid cell closes the ring by taking the head's edge.
    always_comb begin
        case (i_op)
            CELL_ROTATE: n_edge = i_is_last ? i_wrap : i_next;
            CELL_PUSH:   n_edge = i_push;
            default:     n_edge = r_edge;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_edge <= n_edge;
    end

    assign o_edge = r_edge;

endmodule

// File: hdl/emv_edge_chain.sv
// Row of edge cells forming the edge store, with the shared-edge comparator
// at the head cell. Depends on emv_pkg and emv_edge_cell.
`timescale 1ns / 1ps

module emv_edge_chain #(
    parameter int MAX_TRIANGLES = emv_pkg::DefMaxTriangles,
    parameter int COORD_WIDTH   = emv_pkg::DefCoordWidth,
    localparam int Depth = emv_pkg::EdgesPerTri * MAX_TRIANGLES,
    localparam int IdxW  = $clog2(Depth),
    localparam int VW    = 3 * COORD_WIDTH,
    localparam int EW    = 2 * VW
) (
    input  logic              i_clk,
    input  emv_pkg::t_cell_op i_op,
    input  logic [IdxW-1:0]   i_last_idx,
    input  logic [VW-1:0]     i_tri [3],
    input  logic [EW-1:0]     i_new_edge [emv_pkg::EdgesPerTri],
    output logic              o_match
);
    import emv_pkg::*;

    logic [EW-1:0] w_edge [Depth];
    logic [EW-1:0] w_next [Depth];
    logic [EW-1:0] w_push [Depth];
    logic          w_last [Depth];

    for (genvar g = 0; g < Depth; g++) begin : g_cell
        if (g == Depth - 1) begin : g_tail
            assign w_next[g] = w_edge[0];
        end else begin : g_body
            assign w_next[g] = w_edge[g+1];
        end

        // A push moves every edge three places up; the new edges enter at the head.
        if (g < EdgesPerTri) begin : g_new
            assign w_push[g] = i_new_edge[g];
        end else begin : g_old
            assign w_push[g] = w_edge[g-EdgesPerTri];
        end

        assign w_last[g] = (i_last_idx == IdxW'(g));

        emv_edge_cell #(
            .EDGE_WIDTH(EW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_op      (i_op),
            .i_is_last (w_last[g]),
            .i_next    (w_next[g]),
            .i_wrap    (w_edge[0]),
            .i_push    (w_push[g]),
            .o_edge    (w_edge[g])
        );
    end

    // Shared edge: two vertices at different positions match both endpoints.
    logic [2:0] w_eq_a;
    logic [2:0] w_eq_b;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_eq_a[i] = (i_tri[i] == w_edge[0][VW-1:0]);
            w_eq_b[i] = (i_tri[i] == w_edge[0][EW-1:VW]);
        end
        o_match = (w_eq_a[0] && (w_eq_b[1] || w_eq_b[2]))
               || (w_eq_a[1] && (w_eq_b[0] || w_eq_b[2]))
               || (w_eq_a[2] && (w_eq_b[0] || w_eq_b[1]));
    end

endmodule

// File: hdl/emv_ctrl.sv
// Sequencer of the edge validator: pending vertices, counters, the scan over
// the edge ring and the status of each item. Depends on emv_pkg.
`timescale 1ns / 1ps

module emv_ctrl #(
    parameter int MAX_TRIANGLES = emv_pkg::DefMaxTriangles,
    parameter int COORD_WIDTH   = emv_pkg::DefCoordWidth,
    localparam int Depth = emv_pkg::EdgesPerTri * MAX_TRIANGLES,
    localparam int IdxW  = $clog2(Depth),
    localparam int VW    = 3 * COORD_WIDTH,
    localparam int EW    = 2 * VW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_kind,
    input  logic signed [emv_pkg::CoordInW-1:0] i_vx,
    input  logic signed [emv_pkg::CoordInW-1:0] i_vy,
    input  logic signed [emv_pkg::CoordInW-1:0] i_vz,
    input  logic [emv_pkg::LimitW-1:0]        i_limit,
    input  logic                              i_out_free,
    input  logic                              i_match,
    output logic                              o_in_ready,
    output logic                              o_res_we,
    output emv_pkg::t_status                  o_res_status,
    output logic [emv_pkg::TriOutW-1:0]       o_res_tri,
    output logic [emv_pkg::EdgeOutW-1:0]      o_res_edges,
    output emv_pkg::t_cell_op                 o_op,
    output logic [IdxW-1:0]                   o_last_idx,
    output logic [VW-1:0]                     o_tri [3],
    output logic [EW-1:0]                     o_new_edge [emv_pkg::EdgesPerTri]
);
    import emv_pkg::*;

    localparam int TcW  = $clog2(MAX_TRIANGLES + 1);
    localparam int EcW  = $clog2(Depth + 1);
    localparam int CmpW = (TcW > LimitW) ? TcW : LimitW;
    localparam int ExtW = 32;

    t_state            r_state, n_state;
    logic [1:0]        r_slot, n_slot;
    logic [VW-1:0]     r_pend [3];
    logic [VW-1:0]     n_pend [3];
    logic [TcW-1:0]    r_tri_cnt, n_tri_cnt;
    logic [EcW-1:0]    r_edge_cnt, n_edge_cnt;
    logic [IdxW-1:0]   r_scan, n_scan;
    t_status           r_status, n_status;

    logic              w_accept;
    logic              w_full;
    logic              w_degen;
    logic              w_scan_end;
    logic [VW-1:0]     w_vtx;
    logic [EcW-1:0]    w_last_full;
    logic [CmpW-1:0]   w_lim;
    logic [CmpW-1:0]   w_eff_lim;
    logic [ExtW-1:0]   w_ext_x, w_ext_y, w_ext_z;

    // Coordinates are sign-extended, then kept at the configured width.
    assign w_ext_x = {{(ExtW-CoordInW){i_vx[CoordInW-1]}}, i_vx};
    assign w_ext_y = {{(ExtW-CoordInW){i_vy[CoordInW-1]}}, i_vy};
    assign w_ext_z = {{(ExtW-CoordInW){i_vz[CoordInW-1]}}, i_vz};
    assign w_vtx   = {w_ext_z[COORD_WIDTH-1:0], w_ext_y[COORD_WIDTH-1:0],
                      w_ext_x[COORD_WIDTH-1:0]};

    assign w_lim     = CmpW'(i_limit);
    assign w_eff_lim = (w_lim < CmpW'(MAX_TRIANGLES)) ? w_lim : CmpW'(MAX_TRIANGLES);
    assign w_full    = (CmpW'(r_tri_cnt) >= w_eff_lim);

    assign w_degen    = (r_pend[0] == r_pend[1]) && (r_pend[0] == w_vtx);
    assign w_last_full = r_edge_cnt - EcW'(1);
    assign o_last_idx  = w_last_full[IdxW-1:0];
    assign w_scan_end  = (r_scan == o_last_idx);

    assign o_in_ready = (r_state == S_IDLE) && i_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    assign o_tri         = r_pend;
    assign o_new_edge[0] = {r_pend[1], r_pend[0]};
    assign o_new_edge[1] = {r_pend[2], r_pend[0]};
    assign o_new_edge[2] = {r_pend[2], r_pend[1]};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && !i_kind && !w_full && (r_slot == SlotLast) && !w_degen) begin
                    n_state = (r_tri_cnt == '0) ? S_PUSH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_match) begin
                    n_state = S_PUSH;
                end else if (w_scan_end) begin
                    n_state = S_EMIT;
                end
            end
            S_PUSH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates.
    always_comb begin
        n_slot       = r_slot;
        n_pend       = r_pend;
        n_tri_cnt    = r_tri_cnt;
        n_edge_cnt   = r_edge_cnt;
        n_scan       = r_scan;
        n_status     = r_status;
        o_op         = CELL_HOLD;
        o_res_we     = 1'b0;
        o_res_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_kind) begin
                        n_slot       = '0;
                        n_tri_cnt    = '0;
                        n_edge_cnt   = '0;
                        o_res_we     = 1'b1;
                        o_res_status = STAT_CLEARED;
                    end else if (w_full) begin
                        o_res_we     = 1'b1;
                        o_res_status = STAT_FULL;
                    end else begin
                        n_pend[r_slot] = w_vtx;
                        if (r_slot != SlotLast) begin
                            n_slot       = r_slot + 2'd1;
                            o_res_we     = 1'b1;
                            o_res_status = STAT_STORED;
                        end else begin
                            n_slot = '0;
                            n_scan = '0;
                            if (w_degen) begin
                                o_res_we     = 1'b1;
                                o_res_status = STAT_DEGEN;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                if (!i_match) begin
                    o_op = CELL_ROTATE;
                    if (w_scan_end) begin
                        n_status = STAT_NO_EDGE;
                    end else begin
                        n_scan = r_scan + IdxW'(1);
                    end
                end
            end
            S_PUSH: begin
                o_op       = CELL_PUSH;
                n_tri_cnt  = r_tri_cnt + TcW'(1);
                n_edge_cnt = r_edge_cnt + EcW'(EdgesPerTri);
                n_status   = STAT_ACCEPTED;
            end
            S_EMIT: begin
                o_res_we = i_out_free;
            end
            default: begin
                o_op = CELL_HOLD;
            end
        endcase
    end

    assign o_res_tri   = TriOutW'(n_tri_cnt);
    assign o_res_edges = EdgeOutW'(n_edge_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_slot     <= '0;
            r_tri_cnt  <= '0;
            r_edge_cnt <= '0;
            r_scan     <= '0;
        end else begin
            r_state    <= n_state;
            r_slot     <= n_slot;
            r_tri_cnt  <= n_tri_cnt;
            r_edge_cnt <= n_edge_cnt;
            r_scan     <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend   <= n_pend;
        r_status <= n_status;
    end

    // The edge count always equals the triangle count times EdgesPerTri.
    a_edges_track_tris: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_cnt == EcW'(32'(r_tri_cnt) * EdgesPerTri))
        else $error("edge count out of step with triangle count");

    // The scan never walks past the last stored edge.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (EcW'(r_scan) < r_edge_cnt))
        else $error("scan index beyond stored edges");

    // A push only happens while the edge store still has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> (r_tri_cnt < TcW'(MAX_TRIANGLES)))
        else $error("edge push with full store");

    // A push always leads, in the following cycle, to the emit state with the accepted status.
    a_push_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |=> (r_state == S_EMIT) && (r_status == STAT_ACCEPTED))
        else $error("accepted triangle not reported");

endmodule

// File: hdl/triangle_mesh_edge_validator.sv
// Top level of the triangle mesh edge validator: configuration register,
// result register and the sequencer with its edge ring. Depends on emv_pkg,
// the three channel interfaces, emv_ctrl and emv_edge_chain.
`timescale 1ns / 1ps

// Vertices arrive one beat at a time and are grouped in threes into
// triangles; every input beat yields exactly one result beat. A beat that
// stores the first or second vertex of a triangle, a clear beat, a degenerate
// triangle and a vertex ignored because the triangle limit is reached are
// answered in the cycle after acceptance. The first triangle after reset or
// clear is accepted and goes from the push state to the emit state. Any
// later triangle is checked against the stored edges, which sit in a ring of
// 3 * MAX_TRIANGLES edge cells that rotates one place per cycle past a single
// comparator at its head. The check compares the stored edges in turn up to
// the first match. A later triangle goes from the scan state to the push
// state on a match, or to the emit state when no edge matches, and from the
// push state to the emit state; the emit state hands the result to the
// output register. One item is worked on at a time; the next beat is taken
// once the result has entered the output register, and only while that
// register is empty or its beat leaves in the same cycle. The edge store
// needs no clearing pass: only the first edges_stored cells of the ring are
// ever compared.
module triangle_mesh_edge_validator #(
    parameter int MAX_TRIANGLES = emv_pkg::DefMaxTriangles,
    parameter int COORD_WIDTH   = emv_pkg::DefCoordWidth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    emv_in_if.sink     i_in,
    emv_cfg_if.sink    i_cfg,
    emv_out_if.source  o_res
);
    import emv_pkg::*;

    localparam int Depth = EdgesPerTri * MAX_TRIANGLES;
    localparam int IdxW  = $clog2(Depth);
    localparam int VW    = 3 * COORD_WIDTH;
    localparam int EW    = 2 * VW;

    // Triangle limit register; writes are always taken.
    logic [LimitW-1:0] r_limit;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
        end else if (i_cfg.valid) begin
            r_limit <= i_cfg.data;
        end
    end

    // Result register. It is free when empty or when its beat leaves now.
    logic                r_out_valid;
    t_status             r_out_status;
    logic [TriOutW-1:0]  r_out_tri;
    logic [EdgeOutW-1:0] r_out_edges;
    logic                w_out_free;

    logic                w_res_we;
    t_status             w_res_status;
    logic [TriOutW-1:0]  w_res_tri;
    logic [EdgeOutW-1:0] w_res_edges;

    assign w_out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_we) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_we) begin
            r_out_status <= w_res_status;
            r_out_tri    <= w_res_tri;
            r_out_edges  <= w_res_edges;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.status             = r_out_status;
    assign o_res.triangles_accepted = r_out_tri;
    assign o_res.edges_stored       = r_out_edges;

    // Sequencer and edge ring.
    t_cell_op        w_op;
    logic [IdxW-1:0] w_last_idx;
    logic [VW-1:0]   w_tri [3];
    logic [EW-1:0]   w_new_edge [EdgesPerTri];
    logic            w_match;

    emv_ctrl #(
        .MAX_TRIANGLES(MAX_TRIANGLES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_kind       (i_in.kind),
        .i_vx         (i_in.vx),
        .i_vy         (i_in.vy),
        .i_vz         (i_in.vz),
        .i_limit      (r_limit),
        .i_out_free   (w_out_free),
        .i_match      (w_match),
        .o_in_ready   (i_in.ready),
        .o_res_we     (w_res_we),
        .o_res_status (w_res_status),
        .o_res_tri    (w_res_tri),
        .o_res_edges  (w_res_edges),
        .o_op         (w_op),
        .o_last_idx   (w_last_idx),
        .o_tri        (w_tri),
        .o_new_edge   (w_new_edge)
    );

    emv_edge_chain #(
        .MAX_TRIANGLES(MAX_TRIANGLES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_chain (
        .i_clk      (i_clk),
        .i_op       (w_op),
        .i_last_idx (w_last_idx),
        .i_tri      (w_tri),
        .i_new_edge (w_new_edge),
        .o_match    (w_match)
    );

endmodule
